// ===== sv/trs_model_matrix_builder_macros.svh =====
// ----------------------------------------------------------------------------
// trs_model_matrix_builder_macros
// Assertion macros shared by the matrix builder RTL.
// ----------------------------------------------------------------------------
`ifndef TRS_MODEL_MATRIX_BUILDER_MACROS_SVH
`define TRS_MODEL_MATRIX_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define TRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge
`define TRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRS_ASSERT(lbl, prop, msg)
`define TRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants of the model matrix builder.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int FRAC_BITS = 16;

	// angle reduction word
	localparam int B_W = 34;
	localparam logic [B_W-1:0] FULL_DEG    = B_W'(360) << FRAC_BITS;
	localparam logic [B_W-1:0] QUARTER_DEG = B_W'(90) << FRAC_BITS;
	localparam logic [B_W-1:0] QUAD2_DEG   = B_W'(180) << FRAC_BITS;
	localparam logic [B_W-1:0] QUAD3_DEG   = B_W'(270) << FRAC_BITS;
	localparam longint unsigned RED_K =
		((64'd1 << 31) + 64'(FULL_DEG) - 64'd1) / 64'(FULL_DEG);
	localparam logic [B_W-1:0] RED_BIAS = B_W'(RED_K * 64'(FULL_DEG));
	localparam logic [31:0] RED_M = 32'((64'd1 << B_W) / 64'(FULL_DEG));

	localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
	localparam logic [30:0] Q30_ONE     = 31'(1) << 30;
	localparam logic [31:0] ONE_Q       = 32'(1) << FRAC_BITS;

	localparam logic [1:0] ROW_LAST = 2'd3;
	localparam int SC_LAT = 29;

	localparam int SIN_STEPS = 6;
	localparam int COS_STEPS = 7;
	localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [COS_STEPS] =
		'{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [31:0] SIN_REC [SIN_STEPS] = '{
		32'((64'd1 << 32) / 156), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72),
		32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
	localparam logic [31:0] COS_REC [COS_STEPS] = '{
		32'((64'd1 << 32) / 182), 32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90),
		32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12),
		32'((64'd1 << 32) / 2)};

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] position_z;
		logic signed [31:0] yaw_deg;
		logic signed [31:0] pitch_deg;
		logic signed [31:0] roll_deg;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} xf_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last_row;
	} row_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pctl_t;

endpackage

// ===== sv/trs_xf_if.sv =====
// ----------------------------------------------------------------------------
// trs_xf_if
// Transform request channel.
// ----------------------------------------------------------------------------
interface trs_xf_if;
	logic         valid;
	logic         ready;
	trs_pkg::xf_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/trs_row_if.sv =====
// ----------------------------------------------------------------------------
// trs_row_if
// Matrix row request channel.
// ----------------------------------------------------------------------------
interface trs_row_if;
	logic          valid;
	logic          ready;
	trs_pkg::row_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/trs_hstep.sv =====
// ----------------------------------------------------------------------------
// trs_hstep
// One Horner step, t' = max(0, 1 - floor(floor(t*x2)/d)), three stages.
// ----------------------------------------------------------------------------
module trs_hstep (
	input  logic           clk,
	input  logic           arst_n,
	input  trs_pkg::pctl_t ctl,
	input  logic [30:0]    t,
	input  logic [31:0]    x2,
	input  logic [30:0]    aux,
	input  logic [7:0]     div,
	input  logic [31:0]    rec,
	output logic           valid,
	output logic [30:0]    t_out,
	output logic [31:0]    x2_out,
	output logic [30:0]    aux_out
);

	localparam logic [30:0] Q30_ONE_W = trs_pkg::Q30_ONE;

	logic        v_s1, v_s2, v_s3;
	logic [62:0] p_s1;
	logic [31:0] x2_s1, x2_s2, x2_s3;
	logic [30:0] aux_s1, aux_s2, aux_s3;
	logic [31:0] v_word_s2;
	logic [63:0] m_s2;
	logic [30:0] t_s3;

	logic [31:0] q0, qc, rem;
	logic [39:0] qd;
	logic [30:0] t_next;

	// reciprocal estimate is low by at most one
	always_comb begin
		q0 = m_s2[63:32];
		qd = q0 * div;
		rem = v_word_s2 - qd[31:0];
		qc = q0 + {31'd0, (rem >= {24'd0, div})};
		if (qc > {1'b0, Q30_ONE_W}) begin
			t_next = '0;
		end else begin
			t_next = 31'({1'b0, Q30_ONE_W} - qc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			p_s1      <= t * x2;
			x2_s1     <= x2;
			aux_s1    <= aux;
			v_word_s2 <= p_s1[61:30];
			m_s2      <= p_s1[61:30] * rec;
			x2_s2     <= x2_s1;
			aux_s2    <= aux_s1;
			t_s3      <= t_next;
			x2_s3     <= x2_s2;
			aux_s3    <= aux_s2;
		end
	end

	assign valid   = v_s3;
	assign t_out   = t_s3;
	assign x2_out  = x2_s3;
	assign aux_out = aux_s3;

endmodule

// ===== sv/trs_sincos.sv =====
// ----------------------------------------------------------------------------
// trs_sincos
// Degree angle to Q30 sine and cosine: reduction, Horner chains, quadrant.
// ----------------------------------------------------------------------------
module trs_sincos (
	input  logic           clk,
	input  logic           arst_n,
	input  trs_pkg::pctl_t ctl,
	input  logic [31:0]    angle,
	output logic           valid,
	output logic [31:0]    sin_q30,
	output logic [31:0]    cos_q30
);

	typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

	localparam int BW = trs_pkg::B_W;
	localparam int FB = trs_pkg::FRAC_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s26, v_s27, v_s28, v_s29;
	logic [BW-1:0]    b_s1, b_s2, rem_s3, r_s4;
	logic [BW+31:0]   m_s2;
	logic [30:0]      f_s5;
	logic [1:0]       q_s5, q_s6, q_s7;
	logic [55:0]      xp_s6;
	logic [30:0]      x_s7;
	logic [61:0]      x2p_s7;
	logic [61:0]      sp_s26;
	logic [31:0]      s_s27, s_s28;
	logic [31:0]      sin_s29, cos_s29;

	logic [BW+31:0]   qf;
	logic [BW-1:0]    fw;
	logic [1:0]       qn;
	logic [30:0]      xw;
	logic [31:0]      c_w;

	// Horner chains
	logic [30:0] ct [trs_pkg::COS_STEPS+1];
	logic [31:0] cx2 [trs_pkg::COS_STEPS+1];
	logic [30:0] ca [trs_pkg::COS_STEPS+1];
	logic        cv [trs_pkg::COS_STEPS+1];
	logic [30:0] st [trs_pkg::SIN_STEPS+1];
	logic [31:0] sx2 [trs_pkg::SIN_STEPS+1];
	logic [30:0] sa [trs_pkg::SIN_STEPS+1];
	logic        sv [trs_pkg::SIN_STEPS+1];

	always_comb begin
		qf = m_s2[BW+31:BW] * trs_pkg::FULL_DEG;
		xw = xp_s6[FB +: 31];
		c_w = {1'b0, ct[trs_pkg::COS_STEPS]};
		priority if (r_s4 >= trs_pkg::QUAD3_DEG) begin
			qn = QUAD3;
			fw = r_s4 - trs_pkg::QUAD3_DEG;
		end else if (r_s4 >= trs_pkg::QUAD2_DEG) begin
			qn = QUAD2;
			fw = r_s4 - trs_pkg::QUAD2_DEG;
		end else if (r_s4 >= trs_pkg::QUARTER_DEG) begin
			qn = QUAD1;
			fw = r_s4 - trs_pkg::QUARTER_DEG;
		end else begin
			qn = QUAD0;
			fw = r_s4;
		end
	end

	assign ct[0]  = trs_pkg::Q30_ONE;
	assign cx2[0] = x2p_s7[61:30];
	assign ca[0]  = {29'd0, q_s7};
	assign cv[0]  = v_s7;
	assign st[0]  = trs_pkg::Q30_ONE;
	assign sx2[0] = x2p_s7[61:30];
	assign sa[0]  = x_s7;
	assign sv[0]  = v_s7;

	for (genvar k = 0; k < trs_pkg::COS_STEPS; k++) begin : g_cos
		trs_pkg::pctl_t sctl;
		assign sctl.en    = ctl.en;
		assign sctl.valid = cv[k];
		trs_hstep u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (sctl),
			.t       (ct[k]),
			.x2      (cx2[k]),
			.aux     (ca[k]),
			.div     (trs_pkg::COS_DIV[k]),
			.rec     (trs_pkg::COS_REC[k]),
			.valid   (cv[k+1]),
			.t_out   (ct[k+1]),
			.x2_out  (cx2[k+1]),
			.aux_out (ca[k+1])
		);
	end

	for (genvar k = 0; k < trs_pkg::SIN_STEPS; k++) begin : g_sin
		trs_pkg::pctl_t sctl;
		assign sctl.en    = ctl.en;
		assign sctl.valid = sv[k];
		trs_hstep u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (sctl),
			.t       (st[k]),
			.x2      (sx2[k]),
			.aux     (sa[k]),
			.div     (trs_pkg::SIN_DIV[k]),
			.rec     (trs_pkg::SIN_REC[k]),
			.valid   (sv[k+1]),
			.t_out   (st[k+1]),
			.x2_out  (sx2[k+1]),
			.aux_out (sa[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
			v_s28 <= 1'b0;
			v_s29 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s26 <= sv[trs_pkg::SIN_STEPS];
			v_s27 <= v_s26;
			v_s28 <= v_s27;
			v_s29 <= v_s28 & cv[trs_pkg::COS_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// bias by a multiple of 360 so the word is never negative
			b_s1   <= {{(BW-32){angle[31]}}, angle} + trs_pkg::RED_BIAS;
			m_s2   <= b_s1 * trs_pkg::RED_M;
			b_s2   <= b_s1;
			rem_s3 <= b_s2 - qf[BW-1:0];
			r_s4   <= (rem_s3 >= trs_pkg::FULL_DEG) ? rem_s3 - trs_pkg::FULL_DEG : rem_s3;
			f_s5   <= fw[30:0];
			q_s5   <= qn;
			xp_s6  <= f_s5 * trs_pkg::DEG2RAD_Q30;
			q_s6   <= q_s5;
			x_s7   <= xw;
			x2p_s7 <= xw * xw;
			q_s7   <= q_s6;
			sp_s26 <= sa[trs_pkg::SIN_STEPS] * st[trs_pkg::SIN_STEPS];
			s_s27  <= sp_s26[61:30];
			s_s28  <= s_s27;
			unique case (quad_t'(ca[trs_pkg::COS_STEPS][1:0]))
				QUAD0: begin
					sin_s29 <= s_s28;
					cos_s29 <= c_w;
				end
				QUAD1: begin
					sin_s29 <= c_w;
					cos_s29 <= -s_s28;
				end
				QUAD2: begin
					sin_s29 <= -s_s28;
					cos_s29 <= -c_w;
				end
				QUAD3: begin
					sin_s29 <= -c_w;
					cos_s29 <= s_s28;
				end
				default: begin
					sin_s29 <= s_s28;
					cos_s29 <= c_w;
				end
			endcase
		end
	end

	assign valid   = v_s29;
	assign sin_q30 = sin_s29;
	assign cos_q30 = cos_s29;

endmodule

// ===== sv/trs_rot.sv =====
// ----------------------------------------------------------------------------
// trs_rot
// Rotation matrix products, scale and saturation, seven stages.
// ----------------------------------------------------------------------------
module trs_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  trs_pkg::pctl_t     ctl,
	input  logic signed [31:0] sy,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] sx,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] sz,
	input  logic signed [31:0] cz,
	input  trs_pkg::xf_t       side,
	output logic               valid,
	output logic [31:0]        elem [9],
	output trs_pkg::xf_t       side_out
);

	// divide by 2^30, round half away from zero
	function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
		logic signed [65:0] s;
		s = p + (p[65] ? 66'sd536870911 : 66'sd536870912);
		return s[65:30];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -36'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [63:0] p1_s1 [10];
	logic signed [31:0] r2_s2 [10];
	logic signed [31:0] r2_s3 [8];
	logic signed [31:0] r2_s4 [8];
	logic signed [63:0] p3_s3 [4];
	logic signed [31:0] r4_s4 [4];
	logic signed [32:0] rot_s5 [9];
	logic signed [64:0] p6_s6 [9];
	logic signed [31:0] sy_s1, cy_s1, sx_s1, sy_s2, cy_s2, sx_s2, sx_s3, sx_s4;
	trs_pkg::xf_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic signed [35:0] rw [10];
	logic signed [35:0] r4w [4];
	logic signed [35:0] r7w [9];
	logic signed [31:0] sclw [9];

	always_comb begin
		for (int k = 0; k < 10; k++) rw[k] = rnd30(66'(p1_s1[k]));
		for (int k = 0; k < 4; k++) r4w[k] = rnd30(66'(p3_s3[k]));
		for (int k = 0; k < 9; k++) r7w[k] = rnd30(66'(p6_s6[k]));
		for (int i = 0; i < 3; i++) begin
			sclw[3*i]   = side_s5.scale_x;
			sclw[3*i+1] = side_s5.scale_y;
			sclw[3*i+2] = side_s5.scale_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// first products
			p1_s1[0] <= cy * cz;
			p1_s1[1] <= cy * sz;
			p1_s1[2] <= sy * cx;
			p1_s1[3] <= cx * sz;
			p1_s1[4] <= cx * cz;
			p1_s1[5] <= cy * cx;
			p1_s1[6] <= sy * cz;
			p1_s1[7] <= sy * sz;
			p1_s1[8] <= sx * sz;
			p1_s1[9] <= sx * cz;
			sy_s1 <= sy;
			cy_s1 <= cy;
			sx_s1 <= sx;
			side_s1 <= side;
			for (int k = 0; k < 10; k++) r2_s2[k] <= rw[k][31:0];
			sy_s2 <= sy_s1;
			cy_s2 <= cy_s1;
			sx_s2 <= sx_s1;
			side_s2 <= side_s1;
			// products with the pitch-roll terms
			p3_s3[0] <= sy_s2 * r2_s2[8];
			p3_s3[1] <= sy_s2 * r2_s2[9];
			p3_s3[2] <= cy_s2 * r2_s2[8];
			p3_s3[3] <= cy_s2 * r2_s2[9];
			for (int k = 0; k < 8; k++) r2_s3[k] <= r2_s2[k];
			sx_s3 <= sx_s2;
			side_s3 <= side_s2;
			for (int k = 0; k < 4; k++) r4_s4[k] <= r4w[k][31:0];
			for (int k = 0; k < 8; k++) r2_s4[k] <= r2_s3[k];
			sx_s4 <= sx_s3;
			side_s4 <= side_s3;
			rot_s5[0] <= 33'(r2_s4[0]) + 33'(r4_s4[0]);
			rot_s5[1] <= 33'(r4_s4[1]) - 33'(r2_s4[1]);
			rot_s5[2] <= 33'(r2_s4[2]);
			rot_s5[3] <= 33'(r2_s4[3]);
			rot_s5[4] <= 33'(r2_s4[4]);
			rot_s5[5] <= -33'(sx_s4);
			rot_s5[6] <= 33'(r4_s4[2]) - 33'(r2_s4[6]);
			rot_s5[7] <= 33'(r2_s4[7]) + 33'(r4_s4[3]);
			rot_s5[8] <= 33'(r2_s4[5]);
			side_s5 <= side_s4;
			for (int k = 0; k < 9; k++) p6_s6[k] <= 65'(rot_s5[k]) * 65'(sclw[k]);
			side_s6 <= side_s5;
			for (int k = 0; k < 9; k++) elem[k] <= sat32(r7w[k]);
			side_s7 <= side_s6;
		end
	end

	assign valid    = v_s7;
	assign side_out = side_s7;

endmodule

// ===== sv/trs_ser.sv =====
// ----------------------------------------------------------------------------
// trs_ser
// Holds one finished matrix and sends it out as four rows.
// ----------------------------------------------------------------------------
`include "trs_model_matrix_builder_macros.svh"

module trs_ser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [31:0]  elem [9],
	input  trs_pkg::xf_t side,
	output logic         take,
	trs_row_if.source    rows
);

	logic        busy_q;
	logic [1:0]  row_q;
	logic [31:0] elem_q [9];
	logic [31:0] pos_q [3];

	assign take = !busy_q || (rows.ready && (row_q == trs_pkg::ROW_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= 2'd0;
		end else if (take && in_valid) begin
			busy_q <= 1'b1;
			row_q  <= 2'd0;
		end else if (busy_q && rows.ready) begin
			if (row_q == trs_pkg::ROW_LAST) begin
				busy_q <= 1'b0;
				row_q  <= 2'd0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			elem_q   <= elem;
			pos_q[0] <= side.position_x;
			pos_q[1] <= side.position_y;
			pos_q[2] <= side.position_z;
		end
	end

	always_comb begin
		rows.valid             = busy_q;
		rows.payload.row_index = row_q;
		rows.payload.last_row  = (row_q == trs_pkg::ROW_LAST);
		unique case (row_q)
			2'd0: begin
				rows.payload.col0 = elem_q[0];
				rows.payload.col1 = elem_q[1];
				rows.payload.col2 = elem_q[2];
				rows.payload.col3 = pos_q[0];
			end
			2'd1: begin
				rows.payload.col0 = elem_q[3];
				rows.payload.col1 = elem_q[4];
				rows.payload.col2 = elem_q[5];
				rows.payload.col3 = pos_q[1];
			end
			2'd2: begin
				rows.payload.col0 = elem_q[6];
				rows.payload.col1 = elem_q[7];
				rows.payload.col2 = elem_q[8];
				rows.payload.col3 = pos_q[2];
			end
			default: begin
				rows.payload.col0 = '0;
				rows.payload.col1 = '0;
				rows.payload.col2 = '0;
				rows.payload.col3 = trs_pkg::ONE_Q;
			end
		endcase
	end

	`TRS_ASSERT(a_row_step, (rows.valid && rows.ready && (row_q != trs_pkg::ROW_LAST)) |=> (rows.valid && (row_q == $past(row_q) + 2'd1)), "row counter skipped")
	`TRS_ASSERT(a_row_hold, (rows.valid && !rows.ready) |=> (rows.valid && $stable(row_q)), "row moved under stall")
	`TRS_ASSERT(a_idle_row, !rows.valid |-> (row_q == 2'd0), "idle with row not zero")

endmodule

// ===== sv/trs_model_matrix_builder.sv =====
// ----------------------------------------------------------------------------
// trs_model_matrix_builder
// Builds the 4x4 model matrix T*Ry*Rx*Rz*S of one transform, row by row.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// xform    in   valid/ready   trs_pkg::xf_t  position, yaw/pitch/roll, scale
// rows     out  valid/ready   trs_pkg::row_t row_index, col0..col3, last_row
//
// A request enters the pipeline at most once a cycle; the first row leaves
// after 29 sine/cosine stages, 7 rotation stages and 1 row register.
// Sustained throughput is set by the single row port, four rows per request.
// The whole pipeline advances on one enable, so a stall freezes it in place.
// Reset clears valid bits and the row counter only.
// ----------------------------------------------------------------------------
`include "trs_model_matrix_builder_macros.svh"

module trs_model_matrix_builder (
	input  logic      clk,
	input  logic      arst_n,
	trs_xf_if.sink    xform,
	trs_row_if.source rows
);

	logic en, take;
	logic vy, vx, vz, rot_v;
	logic [31:0] sy, cy, sx, cx, sz, cz;
	logic [31:0] elem [9];
	trs_pkg::xf_t side_dly_q [trs_pkg::SC_LAT];
	trs_pkg::xf_t rot_side;
	trs_pkg::pctl_t sc_ctl, rot_ctl;

	// advance whenever the pipeline tail is empty or the row stage takes it
	assign en = !rot_v || take;
	assign xform.ready = en;

	assign sc_ctl.en     = en;
	assign sc_ctl.valid  = xform.valid;
	assign rot_ctl.en    = en;
	assign rot_ctl.valid = vy & vx & vz;

	trs_sincos u_yaw (
		.clk(clk), .arst_n(arst_n), .ctl(sc_ctl), .angle(xform.payload.yaw_deg),
		.valid(vy), .sin_q30(sy), .cos_q30(cy)
	);
	trs_sincos u_pitch (
		.clk(clk), .arst_n(arst_n), .ctl(sc_ctl), .angle(xform.payload.pitch_deg),
		.valid(vx), .sin_q30(sx), .cos_q30(cx)
	);
	trs_sincos u_roll (
		.clk(clk), .arst_n(arst_n), .ctl(sc_ctl), .angle(xform.payload.roll_deg),
		.valid(vz), .sin_q30(sz), .cos_q30(cz)
	);

	// position and scale ride alongside the sine/cosine lanes
	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= xform.payload;
			for (int i = 1; i < trs_pkg::SC_LAT; i++) side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	trs_rot u_rot (
		.clk(clk), .arst_n(arst_n), .ctl(rot_ctl),
		.sy(sy), .cy(cy), .sx(sx), .cx(cx), .sz(sz), .cz(cz),
		.side(side_dly_q[trs_pkg::SC_LAT-1]),
		.valid(rot_v), .elem(elem), .side_out(rot_side)
	);

	trs_ser u_ser (
		.clk(clk), .arst_n(arst_n), .in_valid(rot_v), .elem(elem), .side(rot_side),
		.take(take), .rows(rows)
	);

	`TRS_ASSERT(a_lanes_aligned, (vy == vx) && (vy == vz), "angle lanes out of step")
	`TRS_ASSERT(a_tail_hold, (rot_v && !take) |=> rot_v, "matrix lost under stall")
	`TRS_ASSERT(a_ready_empty, !rot_v |-> xform.ready, "input blocked with empty tail")

endmodule

// ===== bench/trs_model_matrix_builder_tb.sv =====
// ----------------------------------------------------------------------------
// trs_model_matrix_builder_tb
// Drives random and directed transforms into the model matrix builder and
// checks every emitted row against a fixed-point matrix predictor.
// ----------------------------------------------------------------------------
module trs_model_matrix_builder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int DRAIN_CYCLES    = 80;
	localparam int RANDOM_ITEMS    = 380;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	trs_xf_if  xform ();
	trs_row_if rows ();

	trs_model_matrix_builder dut (
		.clk   (clk),
		.arst_n(arst_n),
		.xform (xform.sink),
		.rows  (rows.source)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Matrix predictor and row store
	// ------------------------------------------------------------------
	class matrix_scoreboard;
		trs_pkg::row_t pending_rows[$];
		int   error_count;

		function new();
			error_count = 0;
		endfunction

		// product / 2^30, rounded half away from zero
		function longint round30(longint a, longint b);
			longint p;
			longint m;
			p = a * b;
			m = (p < 0) ? -p : p;
			m = (m + (longint'(1) << 29)) >>> 30;
			return (p < 0) ? -m : m;
		endfunction

		function longint series(longint x2, bit is_cos);
			longint t;
			longint d;
			int n;
			t = longint'(1) << 30;
			n = is_cos ? trs_pkg::COS_STEPS : trs_pkg::SIN_STEPS;
			for (int i = 0; i < n; i++) begin
				d = is_cos ? longint'(trs_pkg::COS_DIV[i]) : longint'(trs_pkg::SIN_DIV[i]);
				t = (longint'(1) << 30) - (((t * x2) >>> 30) / d);
				if (t < 0)
					t = 0;
			end
			return t;
		endfunction

		function void sin_cos(logic signed [31:0] deg, output longint s_o,
				output longint c_o);
			longint full, quarter, r, q, f, x, x2, s, c;
			full    = longint'(360) << trs_pkg::FRAC_BITS;
			quarter = longint'(90) << trs_pkg::FRAC_BITS;
			r = longint'(deg) % full;
			if (r < 0)
				r += full;
			q = r / quarter;
			f = r - q * quarter;
			x = (f * 64'sd18740330) >>> trs_pkg::FRAC_BITS;
			x2 = (x * x) >>> 30;
			s = (x * series(x2, 1'b0)) >>> 30;
			c = series(x2, 1'b1);
			case (q & 3)
				0: begin s_o = s;  c_o = c;  end
				1: begin s_o = c;  c_o = -s; end
				2: begin s_o = -s; c_o = -c; end
				default: begin s_o = -c; c_o = s; end
			endcase
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note_transform(trs_pkg::xf_t t);
			longint sy, cy, sx, cx, sz, cz, sxsz, sxcz;
			longint rot[3][3];
			longint scl[3];
			logic signed [31:0] pos[3];
			trs_pkg::row_t r;
			sin_cos(t.yaw_deg, sy, cy);
			sin_cos(t.pitch_deg, sx, cx);
			sin_cos(t.roll_deg, sz, cz);
			sxsz = round30(sx, sz);
			sxcz = round30(sx, cz);
			rot[0][0] = round30(cy, cz) + round30(sy, sxsz);
			rot[0][1] = -round30(cy, sz) + round30(sy, sxcz);
			rot[0][2] = round30(sy, cx);
			rot[1][0] = round30(cx, sz);
			rot[1][1] = round30(cx, cz);
			rot[1][2] = -sx;
			rot[2][0] = -round30(sy, cz) + round30(cy, sxsz);
			rot[2][1] = round30(sy, sz) + round30(cy, sxcz);
			rot[2][2] = round30(cy, cx);
			scl[0] = t.scale_x;
			scl[1] = t.scale_y;
			scl[2] = t.scale_z;
			pos[0] = t.position_x;
			pos[1] = t.position_y;
			pos[2] = t.position_z;
			for (int i = 0; i < 3; i++) begin
				r.row_index = 2'(i);
				r.col0 = clamp32(round30(rot[i][0], scl[0]));
				r.col1 = clamp32(round30(rot[i][1], scl[1]));
				r.col2 = clamp32(round30(rot[i][2], scl[2]));
				r.col3 = pos[i];
				r.last_row = 1'b0;
				pending_rows.push_back(r);
			end
			r.row_index = trs_pkg::ROW_LAST;
			r.col0 = '0;
			r.col1 = '0;
			r.col2 = '0;
			r.col3 = trs_pkg::ONE_Q;
			r.last_row = 1'b1;
			pending_rows.push_back(r);
		endfunction

		function void check_row(trs_pkg::row_t got);
			trs_pkg::row_t want;
			if (pending_rows.size() == 0) begin
				$error("unexpected row: index %0d", got.row_index);
				error_count++;
				return;
			end
			want = pending_rows.pop_front();
			if (got.row_index !== want.row_index) begin
				$error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
				error_count++;
			end
			if (got.col0 !== want.col0) begin
				$error("col0: expected %0d, actual %0d", want.col0, got.col0);
				error_count++;
			end
			if (got.col1 !== want.col1) begin
				$error("col1: expected %0d, actual %0d", want.col1, got.col1);
				error_count++;
			end
			if (got.col2 !== want.col2) begin
				$error("col2: expected %0d, actual %0d", want.col2, got.col2);
				error_count++;
			end
			if (got.col3 !== want.col3) begin
				$error("col3: expected %0d, actual %0d", want.col3, got.col3);
				error_count++;
			end
			if (got.last_row !== want.last_row) begin
				$error("last_row: expected %0d, actual %0d", want.last_row, got.last_row);
				error_count++;
			end
		endfunction
	endclass

	matrix_scoreboard board = new();

	// idle chances out of a hundred
	int send_idle_pct = 6;
	int recv_idle_pct = 52;
	int idle_cycles   = 0;

	// ------------------------------------------------------------------
	// Row receiver: random stalls, checks each accepted row
	// ------------------------------------------------------------------
	initial rows.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rows.valid && rows.ready)
				board.check_row(rows.payload);
			rows.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: counts cycles with no request accepted on either side
	always @(posedge clk) begin
		if ((xform.valid && xform.ready) || (rows.valid && rows.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Transform sender
	// ------------------------------------------------------------------
	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			// modest values, within +/-128.0 in Q16.16
			3: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			default: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(4))
			// exact multiples of 90 degrees, including quadrant seams
			0: return ($signed($urandom_range(0, 16)) - 8) * (32'sd90 <<< trs_pkg::FRAC_BITS);
			1: return $signed($urandom_range(0, 720 << trs_pkg::FRAC_BITS))
				- (32'sd360 <<< trs_pkg::FRAC_BITS);
			2: return $urandom;
			default: return (($signed($urandom_range(0, 16)) - 8)
				* (32'sd90 <<< trs_pkg::FRAC_BITS)) + $signed($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	// valid drops only while idling, so back-to-back requests keep it high
	task automatic send_transform(trs_pkg::xf_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			xform.valid <= 1'b0;
			@(posedge clk);
		end
		xform.payload <= t;
		xform.valid <= 1'b1;
		do
			@(posedge clk);
		while (!xform.ready);
		board.note_transform(t);
	endtask

	task automatic send_fields(logic signed [31:0] px, py, pz, yaw, pitch, roll, sx, sy, sz);
		trs_pkg::xf_t t;
		t = '{px, py, pz, yaw, pitch, roll, sx, sy, sz};
		send_transform(t);
	endtask

	task automatic send_random();
		trs_pkg::xf_t t;
		t.position_x = rand_word();
		t.position_y = rand_word();
		t.position_z = rand_word();
		t.yaw_deg    = rand_angle();
		t.pitch_deg  = rand_angle();
		t.roll_deg   = rand_angle();
		t.scale_x    = rand_word();
		t.scale_y    = rand_word();
		t.scale_z    = rand_word();
		send_transform(t);
	endtask

	initial begin
		logic signed [31:0] one;
		logic signed [31:0] maxv;
		logic signed [31:0] minv;
		one  = trs_pkg::ONE_Q;
		maxv = 32'sh7fffffff;
		minv = 32'sh80000000;
		xform.valid = 1'b0;
		xform.payload = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, then each axis on its own
		send_fields(0, 0, 0, 0, 0, 0, one, one, one);
		send_fields(one, -one, 5, 90 * one, 0, 0, one, one, one);
		send_fields(0, 0, 0, 0, 90 * one, 0, one, one, one);
		send_fields(0, 0, 0, 0, 0, 90 * one, one, one, one);
		// quadrant seams and negative angles
		send_fields(0, 0, 0, 180 * one, 270 * one, -90 * one, one, one, one);
		send_fields(0, 0, 0, 360 * one, -360 * one, 359 * one, one, one, one);
		send_fields(0, 0, 0, 90 * one - 1, 90 * one + 1, -1, one, one, one);
		send_fields(0, 0, 0, 45 * one, 30 * one, 60 * one, 2 * one, -one, one / 2);
		// huge angles reduce modulo a full turn
		send_fields(maxv, minv, maxv, maxv, minv, maxv, one, one, one);
		send_fields(minv, maxv, minv, minv, maxv, minv, one, one, one);
		// element overflow saturates both ways
		send_fields(0, 0, 0, 0, 0, 0, maxv, maxv, maxv);
		send_fields(0, 0, 0, 0, 0, 0, minv, minv, minv);
		send_fields(0, 0, 0, 180 * one, 0, 0, maxv, minv, minv);
		send_fields(0, 0, 0, 45 * one, 45 * one, 45 * one, maxv, minv, maxv);
		send_fields(-1, 1, 0, 0, 0, 0, 0, -1, 1);
		send_fields(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
			32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0,
			32'sh55555555, 32'shaaaaaaaa, 32'sh33333333);

		// three idling phases over the random part
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 6;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random();
		end
		xform.valid <= 1'b0;

		// drain, then let any trailing output show up
		while (board.pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
